[design/register_rename_next_use_defines.svh]
// ----------------------------------------------------------------------------
// register_rename_next_use assertion macros
// Shared concurrent assertion shorthands. Each expects clk in scope; CHK_NOW and CHK_NEXT also rst_n.
// ----------------------------------------------------------------------------
`ifndef REGISTER_RENAME_NEXT_USE_DEFINES_SVH
`define REGISTER_RENAME_NEXT_USE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication, checked through reset as well.
`define CHK_RAW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/rrnu_pkg.sv]
// ----------------------------------------------------------------------------
// rrnu_pkg
// Widths, instruction kind codes and sequencer states of the rename block.
// ----------------------------------------------------------------------------
package rrnu_pkg;

  localparam int SOURCE_REGS_DEF   = 256;
  localparam int POSITION_BITS_DEF = 16;

  localparam int MODE_W = 3;
  localparam int REG_W  = 8;
  localparam int POS_W  = 16;
  localparam int VIRT_W = 16;
  localparam int NEXT_W = 17;
  localparam int CNT_W  = 9;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_OTHER = 3'd0;
  localparam mode_t MODE_LOAD  = 3'd1;
  localparam mode_t MODE_STORE = 3'd2;
  localparam mode_t MODE_LOADI = 3'd3;
  localparam mode_t MODE_ARITH = 3'd4;

  localparam logic [VIRT_W-1:0] VIRT_MAX   = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
  localparam logic [NEXT_W-1:0] NEXT_NEVER = '1;  // -1, never used again

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

endpackage

[design/register_rename_next_use.sv]
// ----------------------------------------------------------------------------
// register_rename_next_use
// Live-range renaming with next-use marking, one instruction per command.
// ----------------------------------------------------------------------------
// Sequence: each operand touched (load immediate one, load two, store two,
//   arithmetic three) gets a READ state for its table read and an EXEC state
//   for its update; other kinds register their result directly from idle.
// Acceptance: a new instruction is taken only in idle, once the last one is
//   done; table reads and updates use the single-ported map and next-use RAMs.
// Reset: synchronous, active low; then a clearing pass over all SOURCE_REGS
//   entries with busy high. Results are shown one cycle on out_valid and never stall.
// ----------------------------------------------------------------------------
module register_rename_next_use #(
  parameter int SOURCE_REGS   = rrnu_pkg::SOURCE_REGS_DEF,
  parameter int POSITION_BITS = rrnu_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [rrnu_pkg::MODE_W-1:0]        in_mode,
  input  logic [rrnu_pkg::REG_W-1:0]         in_src_reg_a,
  input  logic [rrnu_pkg::REG_W-1:0]         in_src_reg_b,
  input  logic [rrnu_pkg::REG_W-1:0]         in_src_reg_c,
  input  logic [rrnu_pkg::POS_W-1:0]         in_position,
  output logic                               out_valid,
  output logic [rrnu_pkg::VIRT_W-1:0]        out_virt_a,
  output logic signed [rrnu_pkg::NEXT_W-1:0] out_next_a,
  output logic [rrnu_pkg::VIRT_W-1:0]        out_virt_b,
  output logic signed [rrnu_pkg::NEXT_W-1:0] out_next_b,
  output logic [rrnu_pkg::VIRT_W-1:0]        out_virt_c,
  output logic signed [rrnu_pkg::NEXT_W-1:0] out_next_c,
  output logic [rrnu_pkg::CNT_W-1:0]         out_peak_live
);
  import rrnu_pkg::*;

  localparam int IDX_W    = (SOURCE_REGS > 1) ? $clog2(SOURCE_REGS) : 1;
  localparam int POS_KEEP = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;
  localparam logic [POS_W-1:0] POS_MASK = POS_W'((64'd1 << POS_KEEP) - 64'd1);
  localparam int TBL_N = 1 << REG_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SOURCE_REGS - 1);

  // Register number folded into the table depth: constant lookup table.
  logic [IDX_W-1:0] mod_tbl [TBL_N];
  for (genvar gi = 0; gi < TBL_N; gi++) begin : g_mod
    assign mod_tbl[gi] = IDX_W'(gi % SOURCE_REGS);
  end

  // Tables: map entry is {valid, virtual number}; next-use entry is signed.
  logic [VIRT_W:0]   map_mem [SOURCE_REGS];
  logic [NEXT_W-1:0] nu_mem  [SOURCE_REGS];
  logic [VIRT_W:0]   map_rd_r;
  logic [NEXT_W-1:0] nu_rd_r;

  logic              map_we, nu_we;
  logic [VIRT_W:0]   map_wdata;
  logic [NEXT_W-1:0] nu_wdata;
  logic [IDX_W-1:0]  op_idx, wr_idx;

  // Control state
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  // Pending operand slots: [0] definition, [1] use of a, [2] use of b.
  logic [2:0]        pend_r, pend_nxt;
  logic [VIRT_W-1:0] vctr_r, vctr_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0]  peak_r, peak_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Per-instruction payload, no reset needed
  logic              def_c_r, def_c_nxt;
  logic              use_a_r, use_a_nxt;
  logic [IDX_W-1:0]  idx_a_r, idx_a_nxt;
  logic [IDX_W-1:0]  idx_b_r, idx_b_nxt;
  logic [IDX_W-1:0]  idx_c_r, idx_c_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [VIRT_W-1:0] virt_a_r, virt_a_nxt, virt_b_r, virt_b_nxt, virt_c_r, virt_c_nxt;
  logic [NEXT_W-1:0] next_a_r, next_a_nxt, next_b_r, next_b_nxt, next_c_r, next_c_nxt;

  // Decode of the incoming kind
  logic [2:0]        mode_pend;
  logic              mode_def_c;

  always_comb begin
    mode_pend  = 3'b000;
    mode_def_c = 1'b0;
    unique case (in_mode)
      MODE_LOAD:  mode_pend = 3'b011;
      MODE_STORE: mode_pend = 3'b110;
      MODE_LOADI: mode_pend = 3'b001;
      MODE_ARITH: begin
        mode_pend  = 3'b111;
        mode_def_c = 1'b1;
      end
      default:    mode_pend = 3'b000;  // other and unknown kinds touch nothing
    endcase
  end

  // Current slot is the lowest pending one.
  logic [2:0]        cur_oh, pend_left;
  logic              map_valid;
  logic [VIRT_W-1:0] map_virt, op_virt, vctr_inc;

  assign cur_oh[0] = pend_r[0];
  assign cur_oh[1] = pend_r[1] & ~pend_r[0];
  assign cur_oh[2] = pend_r[2] & ~pend_r[1] & ~pend_r[0];
  assign pend_left = pend_r & ~cur_oh;

  always_comb begin
    if (cur_oh[0]) begin
      op_idx = def_c_r ? idx_c_r : idx_b_r;
    end else if (cur_oh[1]) begin
      op_idx = idx_a_r;
    end else begin
      op_idx = idx_b_r;
    end
  end

  assign wr_idx    = (state_r == ST_CLEAR) ? clr_idx_r : op_idx;
  assign map_valid = map_rd_r[VIRT_W];
  assign map_virt  = map_rd_r[VIRT_W-1:0];
  assign op_virt   = map_valid ? map_virt : vctr_r;
  // Virtual counter saturates and hands out its top value again.
  assign vctr_inc  = (vctr_r != VIRT_MAX) ? vctr_r + VIRT_W'(1) : vctr_r;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    pend_nxt      = pend_r;
    vctr_nxt      = vctr_r;
    live_nxt      = live_r;
    out_valid_nxt = 1'b0;
    def_c_nxt     = def_c_r;
    use_a_nxt     = use_a_r;
    idx_a_nxt     = idx_a_r;
    idx_b_nxt     = idx_b_r;
    idx_c_nxt     = idx_c_r;
    pos_nxt       = pos_r;
    virt_a_nxt    = virt_a_r;
    virt_b_nxt    = virt_b_r;
    virt_c_nxt    = virt_c_r;
    next_a_nxt    = next_a_r;
    next_b_nxt    = next_b_r;
    next_c_nxt    = next_c_r;
    map_we        = 1'b0;
    nu_we         = 1'b0;
    map_wdata     = '0;
    nu_wdata      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          idx_a_nxt  = mod_tbl[in_src_reg_a];
          idx_b_nxt  = mod_tbl[in_src_reg_b];
          idx_c_nxt  = mod_tbl[in_src_reg_c];
          pos_nxt    = in_position & POS_MASK;
          pend_nxt   = mode_pend;
          def_c_nxt  = mode_def_c;
          use_a_nxt  = mode_pend[1];
          // untouched operands report zero
          virt_a_nxt = '0;
          virt_b_nxt = '0;
          virt_c_nxt = '0;
          next_a_nxt = '0;
          next_b_nxt = '0;
          next_c_nxt = '0;
          if (mode_pend != 3'b000) begin
            state_nxt = ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end

      ST_CLEAR: begin
        map_we      = 1'b1;
        nu_we       = 1'b1;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_READ: begin
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        if (cur_oh[0]) begin
          // definition: end the live range
          if (!map_valid) begin
            vctr_nxt = vctr_inc;
          end else if (live_r != '0) begin
            live_nxt = live_r - CNT_W'(1);
          end
          map_we    = 1'b1;
          map_wdata = {1'b0, map_virt};
          nu_we     = 1'b1;
          nu_wdata  = NEXT_NEVER;
          if (def_c_r) begin
            virt_c_nxt = op_virt;
            next_c_nxt = nu_rd_r;
          end else begin
            virt_b_nxt = op_virt;
            next_b_nxt = nu_rd_r;
          end
        end else begin
          // use: open a live range if none, then mark this position
          if (!map_valid) begin
            map_we    = 1'b1;
            map_wdata = {1'b1, vctr_r};
            vctr_nxt  = vctr_inc;
            if (live_r != CNT_MAX) begin
              live_nxt = live_r + CNT_W'(1);
            end
          end
          nu_we    = 1'b1;
          nu_wdata = NEXT_W'(pos_r);
          if (cur_oh[1]) begin
            virt_a_nxt = op_virt;
            next_a_nxt = nu_rd_r;
          end else begin
            virt_b_nxt = op_virt;
            // same register as a: report what a saw, not a's fresh mark
            next_b_nxt = (use_a_r && (idx_b_r == idx_a_r)) ? next_a_r : nu_rd_r;
          end
        end
        pend_nxt = pend_left;
        if (pend_left == 3'b000) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_READ;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // live count only rises within an instruction after its definition
    peak_nxt = (live_nxt > peak_r) ? live_nxt : peak_r;
  end

  // Table RAMs, registered read
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[wr_idx] <= map_wdata;
    end
    if (nu_we) begin
      nu_mem[wr_idx] <= nu_wdata;
    end
    map_rd_r <= map_mem[op_idx];
    nu_rd_r  <= nu_mem[op_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      pend_r      <= '0;
      vctr_r      <= '0;
      live_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pend_r      <= pend_nxt;
      vctr_r      <= vctr_nxt;
      live_r      <= live_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    def_c_r  <= def_c_nxt;
    use_a_r  <= use_a_nxt;
    idx_a_r  <= idx_a_nxt;
    idx_b_r  <= idx_b_nxt;
    idx_c_r  <= idx_c_nxt;
    pos_r    <= pos_nxt;
    virt_a_r <= virt_a_nxt;
    virt_b_r <= virt_b_nxt;
    virt_c_r <= virt_c_nxt;
    next_a_r <= next_a_nxt;
    next_b_r <= next_b_nxt;
    next_c_r <= next_c_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_virt_a    = virt_a_r;
  assign out_next_a    = next_a_r;
  assign out_virt_b    = virt_b_r;
  assign out_next_b    = next_b_r;
  assign out_virt_c    = virt_c_r;
  assign out_next_c    = next_c_r;
  assign out_peak_live = peak_r;

endmodule

[design/rrnu_checker.sv]
// ----------------------------------------------------------------------------
// rrnu_checker
// Port-level checks of the rename block, bound to the top level.
// ----------------------------------------------------------------------------
`include "register_rename_next_use_defines.svh"

module rrnu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [rrnu_pkg::MODE_W-1:0] in_mode,
  input logic                        out_valid,
  input logic [rrnu_pkg::CNT_W-1:0]  out_peak_live
);
  import rrnu_pkg::*;

  logic beat_in, kind_works;

  assign beat_in    = start && !busy;
  assign kind_works = (in_mode == MODE_LOAD) || (in_mode == MODE_STORE) ||
                      (in_mode == MODE_LOADI) || (in_mode == MODE_ARITH);

  `CHK_NEXT(a_empty_kind_done, beat_in && !kind_works, out_valid && !busy, "empty kind not done in one cycle")
  `CHK_NEXT(a_work_kind_busy, beat_in && kind_works, busy && !out_valid, "working kind did not hold busy")
  `CHK_NOW(a_peak_monotonic, $past(rst_n), out_peak_live >= $past(out_peak_live), "peak live dropped")
  `CHK_RAW(a_clear_after_reset, !$past(rst_n), busy, "clearing pass not busy")

endmodule

bind register_rename_next_use rrnu_checker u_rrnu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_peak_live (out_peak_live)
);
